[sv/slir_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slir_pkg
// Shared constants for the sorted list core: capacity, index widths and
// status codes.
// ----------------------------------------------------------------------------
package slir_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

endpackage
`default_nettype wire

[sv/sorted_list_insert_remove_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_core
// Sorted list of signed 32-bit values with insert and remove requests.
// ----------------------------------------------------------------------------
// One request is handled at a time and the input stalls until its result word
// has been taken. The values sit in a single-port-read RAM and one comparator
// walks it one entry at a time (read, then compare and move). An insert
// shifts up every stored value not less than the new one; a remove scans the
// whole list. Every result ends with a read of entry zero for the smallest
// value.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_core
  import slir_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                req_type_i,
  input  wire logic signed [31:0]  value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic              [1:0]  status_o,
  output logic              [4:0]  count_o,
  output logic signed       [31:0] smallest_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_REM_RD  = 3'd3;
  localparam logic [2:0] S_REM_CMP = 3'd4;
  localparam logic [2:0] S_SM_RD   = 3'd5;
  localparam logic [2:0] S_SM_WAIT = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [2:0]               state_q, state_d;
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic [CNT_W-1:0]         k_q, k_d;
  logic [IDX_W-1:0]         j_q, j_d;
  logic                     found_q, found_d;
  logic [1:0]               status_q, status_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic signed [DATA_W-1:0] smallest_q, smallest_d;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]         ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  slir_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    k_d        = k_q;
    j_d        = j_q;
    found_d    = found_q;
    status_d   = status_q;
    value_d    = value_q;
    smallest_d = smallest_q;
    ram_we     = 1'b0;
    ram_waddr  = j_q;
    ram_wdata  = value_q;
    ram_raddr  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          value_d  = value_i;
          status_d = ST_OK;
          found_d  = 1'b0;
          k_d      = '0;
          j_d      = fill_q[IDX_W-1:0];
          if (req_type_i == REQ_INSERT) begin
            if (fill_q >= CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_SM_RD;
            end else begin
              state_d = S_INS_RD;
            end
          end else begin
            if (fill_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_SM_RD;
            end else begin
              state_d = S_REM_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        ram_raddr = j_q - 1'b1;
        if (j_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = value_q;
          fill_d    = fill_q + 1'b1;
          state_d   = S_SM_RD;
        end else begin
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        if ($signed(ram_rdata) >= value_q) begin
          ram_wdata = ram_rdata;
          j_d       = j_q - 1'b1;
          state_d   = S_INS_RD;
        end else begin
          ram_wdata = value_q;
          fill_d    = fill_q + 1'b1;
          state_d   = S_SM_RD;
        end
      end
      S_REM_RD: begin
        ram_raddr = k_q[IDX_W-1:0];
        if (k_q == fill_q) begin
          if (found_q) begin
            fill_d = fill_q - 1'b1;
          end else begin
            status_d = ST_NOTFOUND;
          end
          state_d = S_SM_RD;
        end else begin
          state_d = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        ram_waddr = k_q[IDX_W-1:0] - 1'b1;
        ram_wdata = ram_rdata;
        if (found_q) begin
          ram_we = 1'b1;
        end else if (ram_rdata == value_q) begin
          found_d = 1'b1;
        end
        k_d     = k_q + 1'b1;
        state_d = S_REM_RD;
      end
      S_SM_RD: begin
        ram_raddr = '0;
        if (fill_q == '0) begin
          smallest_d = '0;
          state_d    = S_OUT;
        end else begin
          state_d = S_SM_WAIT;
        end
      end
      S_SM_WAIT: begin
        smallest_d = ram_rdata;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      k_q     <= '0;
      j_q     <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      k_q     <= k_d;
      j_q     <= j_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    value_q    <= value_d;
    smallest_q <= smallest_d;
  end

  assign count_ext   = {{COUNT_W{1'b0}}, fill_q};
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign status_o    = status_q;
  assign count_o     = count_ext[COUNT_W-1:0];
  assign smallest_o  = smallest_q;

endmodule
`default_nettype wire

[sv/slir_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slir_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module slir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
